// ----- rtl/sm83_alu_pkg.sv -----
// Package for the SM83 ALU with flags: operation codes and the item structs
// passed between the top level and the ALU core. No dependencies.
`timescale 1ns / 1ps

package sm83_alu_pkg;

    localparam int OP_W = 4;

    localparam logic [OP_W-1:0] OP_INC    = 4'd0;
    localparam logic [OP_W-1:0] OP_DEC    = 4'd1;
    localparam logic [OP_W-1:0] OP_AND    = 4'd2;
    localparam logic [OP_W-1:0] OP_OR     = 4'd3;
    localparam logic [OP_W-1:0] OP_CP     = 4'd4;
    localparam logic [OP_W-1:0] OP_ADD_SP = 4'd5;
    localparam logic [OP_W-1:0] OP_INC16  = 4'd6;
    localparam logic [OP_W-1:0] OP_DEC16  = 4'd7;
    localparam logic [OP_W-1:0] OP_PACK   = 4'd8;
    localparam logic [OP_W-1:0] OP_UNPACK = 4'd9;

    localparam logic [3:0] NIB_MASK  = 4'hF;

    // Flag positions in the packed flag byte
    localparam int FLAG_Z_BIT = 7;
    localparam int FLAG_N_BIT = 6;
    localparam int FLAG_H_BIT = 5;
    localparam int FLAG_C_BIT = 4;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [7:0]      acc_value;
        logic [7:0]      operand;
        logic [15:0]     wide_value;
        logic            zero_in;
        logic            sub_in;
        logic            half_in;
        logic            carry_in;
    } t_alu_in;

    typedef struct packed {
        logic [7:0]  byte_result;
        logic [15:0] word_result;
        logic        zero_out;
        logic        sub_out;
        logic        half_out;
        logic        carry_out;
    } t_alu_out;

endpackage

// ----- rtl/sm83_alu_core.sv -----
// Combinational ALU core: computes the result byte or word and the new
// Z/N/H/C flags for one item. Depends on sm83_alu_pkg.
`timescale 1ns / 1ps

module sm83_alu_core (
    input  sm83_alu_pkg::t_alu_in  i_item,
    output sm83_alu_pkg::t_alu_out o_res
);
    import sm83_alu_pkg::*;

    logic [8:0]  cp_diff;
    logic [4:0]  cp_nib_diff;
    logic [4:0]  sp_nib_sum;
    logic [8:0]  sp_byte_sum;
    logic [15:0] sp_offset;

    assign cp_diff     = {1'b0, i_item.acc_value} - {1'b0, i_item.operand};
    assign cp_nib_diff = {1'b0, i_item.acc_value[3:0]} - {1'b0, i_item.operand[3:0]};
    assign sp_nib_sum  = {1'b0, i_item.wide_value[3:0]} + {1'b0, i_item.operand[3:0]};
    assign sp_byte_sum = {1'b0, i_item.wide_value[7:0]} + {1'b0, i_item.operand};
    assign sp_offset   = {{8{i_item.operand[7]}}, i_item.operand};

    always_comb begin
        o_res.byte_result = 8'h00;
        o_res.word_result = 16'h0000;
        o_res.zero_out    = i_item.zero_in;
        o_res.sub_out     = i_item.sub_in;
        o_res.half_out    = i_item.half_in;
        o_res.carry_out   = i_item.carry_in;

        case (i_item.op)
            OP_INC: begin
                o_res.byte_result = i_item.operand + 8'd1;
                o_res.zero_out    = (o_res.byte_result == 8'h00);
                o_res.sub_out     = 1'b0;
                o_res.half_out    = (i_item.operand[3:0] == NIB_MASK);
            end
            OP_DEC: begin
                o_res.byte_result = i_item.operand - 8'd1;
                o_res.zero_out    = (o_res.byte_result == 8'h00);
                o_res.sub_out     = 1'b1;
                // half borrow out of the low nibble
                o_res.half_out    = (i_item.operand[3:0] == 4'h0);
            end
            OP_AND: begin
                o_res.byte_result = i_item.acc_value & i_item.operand;
                o_res.zero_out    = (o_res.byte_result == 8'h00);
                o_res.sub_out     = 1'b0;
                o_res.half_out    = 1'b1;
                o_res.carry_out   = 1'b0;
            end
            OP_OR: begin
                o_res.byte_result = i_item.acc_value | i_item.operand;
                o_res.zero_out    = (o_res.byte_result == 8'h00);
                o_res.sub_out     = 1'b0;
                o_res.half_out    = 1'b0;
                o_res.carry_out   = 1'b0;
            end
            OP_CP: begin
                o_res.byte_result = cp_diff[7:0];
                o_res.zero_out    = (cp_diff[7:0] == 8'h00);
                o_res.sub_out     = 1'b1;
                o_res.half_out    = cp_nib_diff[4];
                o_res.carry_out   = cp_diff[8];
            end
            OP_ADD_SP: begin
                o_res.word_result = i_item.wide_value + sp_offset;
                o_res.zero_out    = 1'b0;
                o_res.sub_out     = 1'b0;
                // H and C come from the unsigned low-byte sum
                o_res.half_out    = sp_nib_sum[4];
                o_res.carry_out   = sp_byte_sum[8];
            end
            OP_INC16: begin
                o_res.word_result = i_item.wide_value + 16'd1;
            end
            OP_DEC16: begin
                o_res.word_result = i_item.wide_value - 16'd1;
            end
            OP_PACK: begin
                o_res.byte_result[FLAG_Z_BIT] = i_item.zero_in;
                o_res.byte_result[FLAG_N_BIT] = i_item.sub_in;
                o_res.byte_result[FLAG_H_BIT] = i_item.half_in;
                o_res.byte_result[FLAG_C_BIT] = i_item.carry_in;
            end
            OP_UNPACK: begin
                o_res.zero_out  = i_item.operand[FLAG_Z_BIT];
                o_res.sub_out   = i_item.operand[FLAG_N_BIT];
                o_res.half_out  = i_item.operand[FLAG_H_BIT];
                o_res.carry_out = i_item.operand[FLAG_C_BIT];
            end
            default: begin
                // unused codes: zero results, flags pass through
            end
        endcase
    end

endmodule

// ----- rtl/sm83_alu_flags.sv -----
// Top level of the SM83 ALU with flags: input register, ALU core and result
// register with valid/stall handshakes. Depends on sm83_alu_pkg, sm83_alu_core.
`timescale 1ns / 1ps

// Two-stage pipeline: an item is captured in the input register, passes the
// combinational ALU core and lands in the result register, from which its
// result is offered. One item is taken every cycle as
// long as the result side keeps up; a stall on the result side holds both
// stages and is passed straight back to the input as o_stall. Every item
// yields exactly one result item, in order.
module sm83_alu_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_op,
    input  logic [7:0]  i_acc_value,
    input  logic [7:0]  i_operand,
    input  logic [15:0] i_wide_value,
    input  logic        i_zero_in,
    input  logic        i_sub_in,
    input  logic        i_half_in,
    input  logic        i_carry_in,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_byte_result,
    output logic [15:0] o_word_result,
    output logic        o_zero_out,
    output logic        o_sub_out,
    output logic        o_half_out,
    output logic        o_carry_out
);
    import sm83_alu_pkg::*;

    logic     advance;
    logic     r_s1_valid;
    t_alu_in  r_s1;
    t_alu_in  n_s1;
    logic     r_out_valid;
    t_alu_out r_out;
    t_alu_out n_out;

    // hold both stages while a finished result is refused
    assign advance = !(r_out_valid && i_stall);
    assign o_stall = !advance;

    assign n_s1.op         = i_op;
    assign n_s1.acc_value  = i_acc_value;
    assign n_s1.operand    = i_operand;
    assign n_s1.wide_value = i_wide_value;
    assign n_s1.zero_in    = i_zero_in;
    assign n_s1.sub_in     = i_sub_in;
    assign n_s1.half_in    = i_half_in;
    assign n_s1.carry_in   = i_carry_in;

    sm83_alu_core u_core (
        .i_item (r_s1),
        .o_res  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= i_valid;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1  <= n_s1;
            r_out <= n_out;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_byte_result = r_out.byte_result;
    assign o_word_result = r_out.word_result;
    assign o_zero_out    = r_out.zero_out;
    assign o_sub_out     = r_out.sub_out;
    assign o_half_out    = r_out.half_out;
    assign o_carry_out   = r_out.carry_out;

    // a refused result must push back on the input side
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> o_stall)
        else $error("result refused but input not stalled");

    // an accepted item sits in the input register on the next cycle
    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s1_valid)
        else $error("accepted item lost in input stage");

    // when the pipe moves, the result stage takes the input stage's item
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |=> (o_valid == $past(r_s1_valid)))
        else $error("item dropped or invented between stages");

endmodule
